// File: src/sfbm_pkg.sv
`timescale 1ns / 1ps

package sfbm_pkg;

   // bus geometry
   localparam int MAX_MODULES     = 32;
   localparam int BITS_PER_MODULE = 16;
   localparam int MOD_IDX_W       = $clog2(MAX_MODULES);
   localparam int BIT_IDX_W       = $clog2(BITS_PER_MODULE);
   localparam int MOD_CNT_W       = MOD_IDX_W + 1;
   localparam int ADDR_W          = 9;

   // register widths
   localparam int MODCNT_REG_W = 6;
   localparam int TICK_W       = 8;
   localparam int POLL_W       = 24;
   localparam int CSR_DATA_W   = 24;
   localparam int CSR_IDX_W    = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODULE_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_TICKS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_CLOCK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_PULSE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_INTERVAL = 3'd4;

   // register reset values
   localparam logic [MODCNT_REG_W-1:0] MODULE_COUNT_RST  = 6'd2;
   localparam logic [TICK_W-1:0]       LOAD_TICKS_RST    = 8'd10;
   localparam logic [TICK_W-1:0]       HALF_CLOCK_RST    = 8'd30;
   localparam logic [TICK_W-1:0]       RESET_PULSE_RST   = 8'd30;
   localparam logic [POLL_W-1:0]       POLL_INTERVAL_RST = 24'd20000;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
   localparam logic [POLL_W-1:0] POLL_MAX = {POLL_W{1'b1}};

   typedef logic [BITS_PER_MODULE-1:0] sample_word_type;

   // a zero tick count behaves as one
   function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
      return (v == '0) ? TICK_W'(1) : v;
   endfunction

endpackage

// File: src/s88_feedback_bus_master.sv
`timescale 1ns / 1ps

// s88 feedback bus master. Each accepted req beat is one bus tick carrying the
// sampled data line; each tick yields exactly one rsp beat with the clock, load
// and reset line levels for that tick plus an optional debounced sensor event.
// Ticks are taken one per clock cycle unless rsp stalls: all tick work is one
// pass of logic from the phase/counter registers into the rsp output register,
// and a new tick is accepted while a held rsp beat is taken in the same cycle.
// A cycle of the bus runs load, shift-in (two half clock periods per bit),
// debounce (one bit per tick over module_count * 16 bits) and the reset pulse,
// then waits until poll_interval_ticks have passed since shift-in ended. The
// user must write registers through the csr port while the bus is quiet; the
// block does not enforce it. Sample stores are flip-flops, cleared by reset.
module s88_feedback_bus_master (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_data_line,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_clock_line,
   output logic                              rsp_load_line,
   output logic                              rsp_reset_line,
   output logic                              rsp_event_valid,
   output logic [sfbm_pkg::ADDR_W-1:0]       rsp_sensor_address,
   output logic                              rsp_sensor_value,
   input  logic                              csr_write_en,
   input  logic [sfbm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfbm_pkg::CSR_DATA_W-1:0]   csr_data
);

   import sfbm_pkg::*;

   typedef enum logic [1:0] {
      PH_LOAD,
      PH_SHIFT,
      PH_DEBOUNCE,
      PH_RESET
   } phase_type;

   // configuration registers
   logic [MODCNT_REG_W-1:0] module_count_ff;
   logic [TICK_W-1:0]       load_ticks_ff;
   logic [TICK_W-1:0]       half_clock_ff;
   logic [TICK_W-1:0]       reset_pulse_ff;
   logic [POLL_W-1:0]       poll_interval_ff;

   // sequencer state
   phase_type              phase_ff,  phase_in;
   logic [TICK_W-1:0]      timer_ff,  timer_in;
   logic [POLL_W-1:0]      poll_ff,   poll_in;
   logic [MOD_CNT_W-1:0]   mod_idx_ff, mod_idx_in;
   logic [BIT_IDX_W-1:0]   bit_idx_ff, bit_idx_in;
   logic                   clk_lvl_ff, clk_lvl_in;

   // sample stores
   sample_word_type new_sample_ff  [MAX_MODULES];
   sample_word_type prev_sample_ff [MAX_MODULES];
   sample_word_type stable_ff      [MAX_MODULES];

   // rsp output register
   logic                 rsp_valid_ff;
   logic                 out_clock_ff, out_clock_in;
   logic                 out_load_ff,  out_load_in;
   logic                 out_reset_ff, out_reset_in;
   logic                 out_event_ff, out_event_in;
   logic [ADDR_W-1:0]    out_addr_ff,  out_addr_in;
   logic                 out_value_ff, out_value_in;

   logic                 req_fire;
   logic [MOD_CNT_W-1:0] mods_used;
   logic [MOD_IDX_W-1:0] mod_sel;
   logic [TICK_W-1:0]    timer_inc;
   logic [POLL_W-1:0]    poll_inc;
   logic                 ns_bit, ps_bit, st_bit;
   logic                 clear_samples;
   logic                 capture_bit;
   logic                 debounce_step;
   logic                 stable_write;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // module count clamped to one..MAX_MODULES
   always_comb begin
      if (module_count_ff == '0) begin
         mods_used = MOD_CNT_W'(1);
      end else if (MOD_CNT_W'(module_count_ff) > MOD_CNT_W'(MAX_MODULES)) begin
         mods_used = MOD_CNT_W'(MAX_MODULES);
      end else begin
         mods_used = MOD_CNT_W'(module_count_ff);
      end
   end

   assign mod_sel   = mod_idx_ff[MOD_IDX_W-1:0];
   assign timer_inc = (timer_ff == TICK_MAX) ? timer_ff : timer_ff + TICK_W'(1);
   assign poll_inc  = (poll_ff == POLL_MAX) ? poll_ff : poll_ff + POLL_W'(1);
   assign ns_bit    = new_sample_ff[mod_sel][bit_idx_ff];
   assign ps_bit    = prev_sample_ff[mod_sel][bit_idx_ff];
   assign st_bit    = stable_ff[mod_sel][bit_idx_ff];

   // one tick of the bus sequencer
   always_comb begin
      phase_in      = phase_ff;
      timer_in      = timer_ff;
      poll_in       = poll_ff;
      mod_idx_in    = mod_idx_ff;
      bit_idx_in    = bit_idx_ff;
      clk_lvl_in    = clk_lvl_ff;
      out_clock_in  = 1'b0;
      out_load_in   = 1'b0;
      out_reset_in  = 1'b0;
      out_event_in  = 1'b0;
      out_addr_in   = '0;
      out_value_in  = 1'b0;
      clear_samples = 1'b0;
      capture_bit   = 1'b0;
      debounce_step = 1'b0;
      stable_write  = 1'b0;
      unique case (phase_ff)
         PH_LOAD: begin
            out_load_in = 1'b1;
            timer_in    = timer_inc;
            if (timer_inc >= at_least_one(load_ticks_ff)) begin
               phase_in      = PH_SHIFT;
               timer_in      = '0;
               mod_idx_in    = '0;
               bit_idx_in    = '0;
               clk_lvl_in    = 1'b0;
               clear_samples = 1'b1;
            end
         end
         PH_SHIFT: begin
            timer_in = timer_inc;
            if (timer_inc >= at_least_one(half_clock_ff)) begin
               timer_in   = '0;
               clk_lvl_in = !clk_lvl_ff;
               // rising edge takes one data bit
               if (!clk_lvl_ff) begin
                  capture_bit = 1'b1;
                  bit_idx_in  = bit_idx_ff + BIT_IDX_W'(1);
                  if (bit_idx_ff == BIT_IDX_W'(BITS_PER_MODULE - 1)) begin
                     mod_idx_in = mod_idx_ff + MOD_CNT_W'(1);
                  end
               end
            end
            out_clock_in = clk_lvl_in;
            if (mod_idx_in >= mods_used) begin
               phase_in   = PH_DEBOUNCE;
               timer_in   = '0;
               mod_idx_in = '0;
               bit_idx_in = '0;
               clk_lvl_in = 1'b0;
               poll_in    = '0;
            end
         end
         PH_DEBOUNCE: begin
            debounce_step = 1'b1;
            poll_in       = poll_inc;
            // two equal samples that differ from the stable level
            if (ns_bit == ps_bit && ns_bit != st_bit) begin
               stable_write = 1'b1;
               out_event_in = 1'b1;
               out_addr_in  = {mod_sel, bit_idx_ff};
               out_value_in = ns_bit;
            end
            bit_idx_in = bit_idx_ff + BIT_IDX_W'(1);
            if (bit_idx_ff == BIT_IDX_W'(BITS_PER_MODULE - 1)) begin
               mod_idx_in = mod_idx_ff + MOD_CNT_W'(1);
            end
            if (mod_idx_in >= mods_used) begin
               phase_in   = PH_RESET;
               timer_in   = '0;
               mod_idx_in = '0;
               bit_idx_in = '0;
            end
         end
         PH_RESET: begin
            out_reset_in = timer_ff < at_least_one(reset_pulse_ff);
            timer_in     = timer_inc;
            poll_in      = poll_inc;
            if (poll_inc >= poll_interval_ff) begin
               phase_in = PH_LOAD;
               timer_in = '0;
            end
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         module_count_ff  <= MODULE_COUNT_RST;
         load_ticks_ff    <= LOAD_TICKS_RST;
         half_clock_ff    <= HALF_CLOCK_RST;
         reset_pulse_ff   <= RESET_PULSE_RST;
         poll_interval_ff <= POLL_INTERVAL_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODULE_COUNT:  module_count_ff  <= csr_data[MODCNT_REG_W-1:0];
            CSR_LOAD_TICKS:    load_ticks_ff    <= csr_data[TICK_W-1:0];
            CSR_HALF_CLOCK:    half_clock_ff    <= csr_data[TICK_W-1:0];
            CSR_RESET_PULSE:   reset_pulse_ff   <= csr_data[TICK_W-1:0];
            CSR_POLL_INTERVAL: poll_interval_ff <= csr_data[POLL_W-1:0];
            default: ;
         endcase
      end
   end

   // state and rsp output register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LOAD;
         timer_ff     <= '0;
         poll_ff      <= '0;
         mod_idx_ff   <= '0;
         bit_idx_ff   <= '0;
         clk_lvl_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff     <= phase_in;
            timer_ff     <= timer_in;
            poll_ff      <= poll_in;
            mod_idx_ff   <= mod_idx_in;
            bit_idx_ff   <= bit_idx_in;
            clk_lvl_ff   <= clk_lvl_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // rsp payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         out_clock_ff <= out_clock_in;
         out_load_ff  <= out_load_in;
         out_reset_ff <= out_reset_in;
         out_event_ff <= out_event_in;
         out_addr_ff  <= out_addr_in;
         out_value_ff <= out_value_in;
      end
   end

   // sample, previous-sample and stable stores
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_MODULES; i++) begin
            new_sample_ff[i]  <= '0;
            prev_sample_ff[i] <= '0;
            stable_ff[i]      <= '0;
         end
      end else if (req_fire) begin
         if (clear_samples) begin
            for (int i = 0; i < MAX_MODULES; i++) begin
               new_sample_ff[i] <= '0;
            end
         end
         if (capture_bit) begin
            new_sample_ff[mod_sel][bit_idx_ff] <= ns_bit | req_data_line;
         end
         if (debounce_step) begin
            prev_sample_ff[mod_sel][bit_idx_ff] <= ns_bit;
         end
         if (stable_write) begin
            stable_ff[mod_sel][bit_idx_ff] <= ns_bit;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_clock_line     = out_clock_ff;
   assign rsp_load_line      = out_load_ff;
   assign rsp_reset_line     = out_reset_ff;
   assign rsp_event_valid    = out_event_ff;
   assign rsp_sensor_address = out_addr_ff;
   assign rsp_sensor_value   = out_value_ff;

   // clock level only rests high inside shift-in
   a_clock_rests_low: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_SHIFT |-> !clk_lvl_ff)
      else $error("clock level high outside shift-in");

   // module counter always points inside the sample stores
   a_mod_idx_range: assert property (@(posedge clock) disable iff (reset)
      mod_idx_ff < MOD_CNT_W'(MAX_MODULES))
      else $error("module index beyond sample stores");

   // events only come from a debounce tick
   a_event_from_debounce: assert property (@(posedge clock) disable iff (reset)
      req_fire && out_event_in |=> rsp_event_valid && $past(phase_ff) == PH_DEBOUNCE)
      else $error("event outside debounce");

   // load line never driven together with the clock or reset line
   a_lines_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_load_line && (rsp_clock_line || rsp_reset_line)))
      else $error("load line overlaps clock or reset line");

endmodule
